// ===== sv/bounded_decimal_integer_parser_defines.svh =====
// Assertion macros for the checker file of the decimal integer parser.
`ifndef BOUNDED_DECIMAL_INTEGER_PARSER_DEFINES_SVH
`define BOUNDED_DECIMAL_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define BDIP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define BDIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that is also checked during reset.
`define BDIP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/bdip_pkg.sv =====
// Types and constants of the bounded decimal integer parser.
package bdip_pkg;

  localparam int VALUE_W = 64;
  // Ten times a 64-bit value plus a digit, with sign: four extra bits.
  localparam int WIDE_W = VALUE_W + 4;
  localparam int CHAR_W = 8;
  localparam int STATUS_W = 2;
  localparam int PHASE_W = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int DIGIT_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_BOUND = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_BOUND = 1'd1;

  localparam logic signed [VALUE_W-1:0] LOWER_RESET = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] UPPER_RESET = {1'b0, {(VALUE_W-1){1'b1}}};

  // Parse phases.
  localparam logic [PHASE_W-1:0] PH_SPACE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HIGH   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LOW    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BAD    = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LARGE   = 2'd3;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [PHASE_W-1:0]        phase;
    logic                      negative;
    logic signed [VALUE_W-1:0] acc;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{phase: PH_SPACE, negative: 1'b0, acc: '0};

endpackage

// ===== sv/bdip_if.sv =====
// Item channels of the decimal integer parser: characters in, results out.
interface bdip_char_if;
  logic                          valid;
  logic                          ready;
  logic [bdip_pkg::CHAR_W-1:0]   char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface bdip_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bdip_pkg::VALUE_W-1:0]  value;
  logic [bdip_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ===== sv/bdip_step.sv =====
// Next-state and result logic for one character of the decimal parser.
module bdip_step (
  input  logic [bdip_pkg::CHAR_W-1:0]          char_byte,
  input  bdip_pkg::parse_state_t               state,
  input  logic signed [bdip_pkg::VALUE_W-1:0]  lower_bound,
  input  logic signed [bdip_pkg::VALUE_W-1:0]  upper_bound,
  output bdip_pkg::parse_state_t               state_next,
  output logic signed [bdip_pkg::VALUE_W-1:0]  res_value,
  output logic [bdip_pkg::STATUS_W-1:0]        res_status
);

  logic                                  is_digit;
  logic                                  is_space;
  logic [bdip_pkg::DIGIT_W-1:0]          digit;
  logic signed [bdip_pkg::WIDE_W-1:0]    acc_wide;
  logic signed [bdip_pkg::WIDE_W-1:0]    times10;
  logic signed [bdip_pkg::WIDE_W-1:0]    up_sum;
  logic signed [bdip_pkg::WIDE_W-1:0]    down_sum;
  logic                                  up_fail;
  logic                                  down_fail;
  logic [bdip_pkg::PHASE_W-1:0]          digit_phase;
  logic signed [bdip_pkg::VALUE_W-1:0]   digit_acc;

  assign is_digit = char_byte inside {[bdip_pkg::CH_ZERO:bdip_pkg::CH_NINE]};
  assign is_space = (char_byte inside {[bdip_pkg::CH_TAB:bdip_pkg::CH_CR]})
                    || (char_byte == bdip_pkg::CH_SPACE);
  assign digit = bdip_pkg::DIGIT_W'(char_byte - bdip_pkg::CH_ZERO);

  // Ten times the accumulator as two shifted copies; the sum is exact, so the
  // bound check is one signed compare instead of a divide by ten.
  assign acc_wide = bdip_pkg::WIDE_W'(state.acc);
  assign times10  = (acc_wide <<< 3) + (acc_wide <<< 1);
  assign up_sum   = times10 + bdip_pkg::WIDE_W'(digit);
  assign down_sum = times10 - bdip_pkg::WIDE_W'(digit);
  assign up_fail   = up_sum > bdip_pkg::WIDE_W'(upper_bound);
  assign down_fail = down_sum < bdip_pkg::WIDE_W'(lower_bound);

  // Outcome of a character in a phase where a digit is expected.
  always_comb begin
    digit_acc = state.acc;
    if (!is_digit) begin
      digit_phase = bdip_pkg::PH_BAD;
    end else if (state.negative) begin
      digit_phase = down_fail ? bdip_pkg::PH_LOW : bdip_pkg::PH_DIGITS;
      if (!down_fail) begin
        digit_acc = down_sum[bdip_pkg::VALUE_W-1:0];
      end
    end else begin
      digit_phase = up_fail ? bdip_pkg::PH_HIGH : bdip_pkg::PH_DIGITS;
      if (!up_fail) begin
        digit_acc = up_sum[bdip_pkg::VALUE_W-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    res_value  = '0;
    res_status = bdip_pkg::ST_INVALID;
    if (char_byte == bdip_pkg::CH_NUL) begin
      state_next = bdip_pkg::STATE_RESET;
      if (lower_bound <= upper_bound) begin
        case (state.phase)
          bdip_pkg::PH_DIGITS: begin
            if (state.acc < lower_bound) begin
              res_status = bdip_pkg::ST_SMALL;
            end else if (state.acc > upper_bound) begin
              res_status = bdip_pkg::ST_LARGE;
            end else begin
              res_status = bdip_pkg::ST_OK;
              res_value  = state.acc;
            end
          end
          bdip_pkg::PH_HIGH: res_status = bdip_pkg::ST_LARGE;
          bdip_pkg::PH_LOW:  res_status = bdip_pkg::ST_SMALL;
          default:           res_status = bdip_pkg::ST_INVALID;
        endcase
      end
    end else begin
      case (state.phase)
        bdip_pkg::PH_SPACE: begin
          if (is_space) begin
            state_next.phase = bdip_pkg::PH_SPACE;
          end else if (char_byte == bdip_pkg::CH_PLUS) begin
            state_next.phase = bdip_pkg::PH_SIGN;
          end else if (char_byte == bdip_pkg::CH_MINUS) begin
            state_next.phase    = bdip_pkg::PH_SIGN;
            state_next.negative = 1'b1;
          end else begin
            state_next.phase = digit_phase;
            state_next.acc   = digit_acc;
          end
        end
        bdip_pkg::PH_SIGN, bdip_pkg::PH_DIGITS: begin
          state_next.phase = digit_phase;
          state_next.acc   = digit_acc;
        end
        bdip_pkg::PH_HIGH, bdip_pkg::PH_LOW: begin
          if (!is_digit) begin
            state_next.phase = bdip_pkg::PH_BAD;
          end
        end
        default: state_next.phase = bdip_pkg::PH_BAD;
      endcase
    end
  end

endmodule

// ===== sv/bounded_decimal_integer_parser.sv =====
// Top level of the bounded decimal integer parser.
// The block reads a string one character item per clock cycle and, on each
// zero byte, returns one result item: a signed 64-bit value and a status
// (ok, invalid, too small, too large). Leading whitespace and one sign are
// taken, then decimal digits are accumulated with exact checks against the
// lower_bound and upper_bound registers; every error result carries value 0.
// A character is taken into an input register, and when it moves on, one
// step of logic (a multiply by ten built from two shifted copies, one 68-bit
// add and one bound compare) updates the parse state and, for a zero byte,
// loads the result register. So the block takes one character item every
// cycle while not held, and a result is valid once its zero byte leaves
// the input register. Input items keep flowing while a result waits; only a
// second zero byte meeting a result not yet taken holds the input side. The
// user must write the bounds via the configuration port only while the block
// is idle (unenforced); an item accepted at a write's edge sees the new value.
module bounded_decimal_integer_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  bdip_char_if.sink                            chars,
  bdip_result_if.source                        results,
  input  logic                                 cfg_write,
  input  logic [bdip_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bdip_pkg::VALUE_W-1:0]         cfg_data
);

  // Configuration registers.
  logic signed [bdip_pkg::VALUE_W-1:0] lower_bound;
  logic signed [bdip_pkg::VALUE_W-1:0] upper_bound;

  // Input register.
  logic                          s1_valid;
  logic [bdip_pkg::CHAR_W-1:0]   s1_char;
  logic                          s1_is_end;
  logic                          advance;

  // Parse state.
  bdip_pkg::parse_state_t        state;
  bdip_pkg::parse_state_t        state_next;

  // Result register.
  logic                                  out_valid;
  logic signed [bdip_pkg::VALUE_W-1:0]   out_value;
  logic [bdip_pkg::STATUS_W-1:0]         out_status;
  logic signed [bdip_pkg::VALUE_W-1:0]   res_value;
  logic [bdip_pkg::STATUS_W-1:0]         res_status;

  bdip_step u_step (
    .char_byte   (s1_char),
    .state       (state),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .state_next  (state_next),
    .res_value   (res_value),
    .res_status  (res_status)
  );

  // A held character moves on unless it is a zero byte and the result
  // register still holds a result that has not been taken.
  assign s1_is_end = (s1_char == bdip_pkg::CH_NUL);
  assign advance   = s1_valid && (!s1_is_end || !out_valid || results.ready);
  assign chars.ready = !s1_valid || advance;

  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= bdip_pkg::LOWER_RESET;
      upper_bound <= bdip_pkg::UPPER_RESET;
      s1_valid    <= 1'b0;
      state       <= bdip_pkg::STATE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bdip_pkg::REG_LOWER_BOUND: lower_bound <= cfg_data;
          bdip_pkg::REG_UPPER_BOUND: upper_bound <= cfg_data;
          default: ;
        endcase
      end
      if (chars.ready) begin
        s1_valid <= chars.valid;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && s1_is_end) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.char_byte;
    end
    if (advance && s1_is_end) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

endmodule

// ===== sv/bdip_checker.sv =====
// Port-level checks for the decimal integer parser and their binding.
`include "bounded_decimal_integer_parser_defines.svh"

module bdip_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [bdip_pkg::VALUE_W-1:0]  out_value,
  input logic [bdip_pkg::STATUS_W-1:0]        out_status
);

  // A result that is not taken stays in place unchanged.
  `BDIP_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_value) && $stable(out_status),
    "result changed while stalled")

  // Every error result carries value zero.
  `BDIP_ASSERT_IMPLY(a_error_value_zero, clk, rst,
    out_valid && (out_status != bdip_pkg::ST_OK), out_value == '0,
    "error result with nonzero value")

  // The input side only stalls behind a result that is waiting.
  `BDIP_ASSERT_IMPLY(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready,
    "input stalled without a waiting result")

  // Reset leaves no result on the output.
  `BDIP_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst), !out_valid,
    "result valid right after reset")

endmodule

bind bounded_decimal_integer_parser bdip_checker u_bdip_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (chars.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.value),
  .out_status (results.status)
);

// ===== sim/parse_check_pkg.sv =====
// Scoreboard for the decimal integer parser: string predictor and result queue.
`timescale 1ns / 1ps

package parse_check_pkg;
  import bdip_pkg::*;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
  } parse_result_t;

  class parse_scoreboard;
    longint                    lower_bound;
    longint                    upper_bound;
    logic [PHASE_W-1:0]        phase;
    bit                        negative;
    logic [VALUE_W-1:0]        acc;
    parse_result_t             expected_results[$];
    int                        errors;

    function new();
      lower_bound = LOWER_RESET;
      upper_bound = UPPER_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_SPACE;
      negative = 1'b0;
      acc = '0;
    endfunction

    // Adds one digit on the positive side; returns 0 once upper_bound would be crossed.
    function bit grow_up(logic [VALUE_W-1:0] d);
      longint             n;
      logic [VALUE_W-1:0] n10;
      logic [VALUE_W-1:0] hi;
      n = acc;
      hi = upper_bound;
      if (upper_bound < 0 || n > upper_bound / 10) return 1'b0;
      n10 = acc * 64'd10;
      if (hi - n10 < d) return 1'b0;
      acc = n10 + d;
      return 1'b1;
    endfunction

    // Mirror of grow_up: the value moves down toward lower_bound.
    function bit grow_down(logic [VALUE_W-1:0] d);
      longint             n;
      logic [VALUE_W-1:0] n10;
      logic [VALUE_W-1:0] lo;
      n = acc;
      lo = lower_bound;
      if (lower_bound > 0 || n < lower_bound / 10) return 1'b0;
      n10 = acc * 64'd10;
      if (n10 - lo < d) return 1'b0;
      acc = n10 - d;
      return 1'b1;
    endfunction

    function parse_result_t conclude();
      parse_result_t r;
      longint        n;
      n = acc;
      r.value = '0;
      r.status = ST_INVALID;
      if (lower_bound <= upper_bound) begin
        case (phase)
          PH_DIGITS: begin
            if (n < lower_bound) r.status = ST_SMALL;
            else if (n > upper_bound) r.status = ST_LARGE;
            else begin
              r.value = acc;
              r.status = ST_OK;
            end
          end
          PH_HIGH: r.status = ST_LARGE;
          PH_LOW: r.status = ST_SMALL;
          default: r.status = ST_INVALID;
        endcase
      end
      return r;
    endfunction

    // Advances the parse by one accepted character; a zero byte queues a result.
    function void note_char(logic [CHAR_W-1:0] c);
      bit is_digit;
      bit is_space;
      is_digit = (c >= CH_ZERO && c <= CH_NINE);
      is_space = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
      if (c == CH_NUL) begin
        expected_results.push_back(conclude());
        clear();
        return;
      end
      case (phase)
        PH_SPACE, PH_SIGN, PH_DIGITS: begin
          if (phase == PH_SPACE && is_space) begin
            // Leading whitespace is skipped.
          end else if (phase == PH_SPACE && c == CH_PLUS) begin
            phase = PH_SIGN;
          end else if (phase == PH_SPACE && c == CH_MINUS) begin
            negative = 1'b1;
            phase = PH_SIGN;
          end else if (!is_digit) begin
            phase = PH_BAD;
          end else if (negative) begin
            phase = grow_down(64'(c - CH_ZERO)) ? PH_DIGITS : PH_LOW;
          end else begin
            phase = grow_up(64'(c - CH_ZERO)) ? PH_DIGITS : PH_HIGH;
          end
        end
        PH_HIGH, PH_LOW: begin
          if (!is_digit) phase = PH_BAD;
        end
        default: phase = PH_BAD;
      endcase
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] value, logic [STATUS_W-1:0] status);
      parse_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with no string pending: value %0d, status %0d", value, status);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (value !== e.value) begin
        $error("value: expected %0d, actual %0d", e.value, value);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== sim/testbench.sv =====
// Top-level testbench of the bounded decimal integer parser.
`timescale 1ns / 1ps

module testbench;
  import bdip_pkg::*;
  import parse_check_pkg::*;

  // A run fails if this many cycles pass with no item accepted on either side.
  localparam int STALL_LIMIT = 2000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES = 300;
  // Random characters to send after the directed strings.
  localparam int RANDOM_ITEMS = 150;
  // The last stretch of the random part runs with no idling at all.
  localparam int FLAT_OUT_ITEMS = 80;
  // A character is worked on once it leaves the input register; the settle
  // cycles let every accepted character reach the parse state and the
  // scoreboard before the result queue is checked.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [VALUE_W-1:0]     cfg_data;

  bdip_char_if   chars();
  bdip_result_if results();

  bounded_decimal_integer_parser u_dut (
    .clk,
    .rst,
    .chars(chars),
    .results(results),
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  parse_scoreboard    sb;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  bit                 rx_hold;
  int                 quiet_cycles;
  int                 sent_items;
  logic [CHAR_W-1:0]  text[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Both channels are sampled right after the rising edge, where every input
  // still holds the value the block saw at that edge. Results are checked
  // before the new character is noted; the queue is in order either way,
  // since a result always belongs to an earlier zero byte.
  always @(posedge clk) begin
    if (!rst) begin
      if (results.valid && results.ready) sb.check_result(results.value, results.status);
      if (chars.valid && chars.ready) sb.note_char(chars.char_byte);
      if ((results.valid && results.ready) || (chars.valid && chars.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  // The hold-off is timed here so the sender keeps pushing meanwhile.
  initial begin
    results.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold) begin
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end else begin
        results.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one character item and returns in the time step it is accepted.
  // Valid is left high so that a following item goes out back to back.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    if ($urandom_range(99) < tx_idle_pct) begin
      chars.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    chars.valid <= 1'b1;
    chars.char_byte <= c;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    sent_items++;
  endtask

  // Sends the characters collected in text, with a closing zero byte if asked.
  task automatic send_text(input bit terminate);
    foreach (text[i]) send_char(text[i]);
    if (terminate) send_char(CH_NUL);
    text.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  // Appends a decimal rendering of v, with an optional plus sign and
  // leading zeros after the sign.
  task automatic put_number(input longint v, input bit with_plus, input int zeros);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digits[$];
    mag = v;
    if (v < 0) begin
      mag = -mag;
      text.push_back(CH_MINUS);
    end else if (with_plus) begin
      text.push_back(CH_PLUS);
    end
    repeat (zeros) text.push_back(CH_ZERO);
    do begin
      digits.push_front(8'(CH_ZERO + mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digits[i]) text.push_back(digits[i]);
  endtask

  // Bounds change only with the block idle: no character offered, every
  // accepted character worked on, and no result outstanding.
  // Both registers are written on back-to-back edges with the enable held.
  task automatic set_bounds(input longint lo, input longint hi);
    chars.valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_LOWER_BOUND;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_UPPER_BOUND;
    cfg_data <= hi;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.lower_bound = lo;
    sb.upper_bound = hi;
  endtask

  initial begin
    longint            lo;
    longint            hi;
    longint            target;
    longint            tmp;
    int                kind;
    int                ws;
    int                strings;
    int                random_end;
    logic [CHAR_W-1:0] junk;

    sb = new();
    rst <= 1'b1;
    chars.valid <= 1'b0;
    chars.char_byte <= CH_NUL;
    cfg_write <= 1'b0;
    cfg_index <= REG_LOWER_BOUND;
    cfg_data <= '0;
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    rx_hold = 1'b0;
    quiet_cycles = 0;
    sent_items = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed strings under the reset bounds. An empty string, blanks only
    // (every whitespace code) and a lone sign are all invalid.
    send_text(1'b1);
    text = '{CH_SPACE, CH_TAB, 8'h0a, 8'h0b, 8'h0c, CH_CR};
    send_text(1'b1);
    put_str("-");
    send_text(1'b1);
    put_str(" +42");
    send_text(1'b1);
    put_str("-0");
    send_text(1'b1);
    put_number(UPPER_RESET, 1'b0, 0);
    send_text(1'b1);
    put_str("9223372036854775808");
    send_text(1'b1);
    put_number(LOWER_RESET, 1'b0, 0);
    send_text(1'b1);
    put_str("-9223372036854775809");
    send_text(1'b1);
    // Overflowed past the top, then a non-digit: invalid wins.
    put_str("123456789012345678901+");
    send_text(1'b1);
    put_str("12a");
    send_text(1'b1);
    put_str("+-1");
    send_text(1'b1);
    put_str("1 ");
    send_text(1'b1);
    text = '{8'hff, 8'h80};
    send_text(1'b1);

    // Bounds changed in the middle of a string: the digit after the write
    // already sees the new top.
    put_str("12");
    send_text(1'b0);
    set_bounds(LOWER_RESET, 64'sd5);
    put_str("3");
    send_text(1'b1);

    // Crossed bounds make any string invalid.
    set_bounds(64'sd5, 64'sd3);
    put_str("4");
    send_text(1'b1);

    set_bounds(-64'sd100, 64'sd100);
    put_str("101");
    send_text(1'b1);
    put_str("-101");
    send_text(1'b1);
    put_str("-100");
    send_text(1'b1);
    put_str("1000x");
    send_text(1'b1);

    // A positive value under a positive floor is too small, and so is any
    // negative string there.
    set_bounds(64'sd10, 64'sd100);
    put_str("5");
    send_text(1'b1);
    put_str("-3");
    send_text(1'b1);

    // Mirror case: both bounds negative.
    set_bounds(-64'sd100, -64'sd10);
    put_str("-5");
    send_text(1'b1);
    put_str("5");
    send_text(1'b1);

    set_bounds(64'sd0, 64'sd0);
    put_str("-0");
    send_text(1'b1);
    put_str("-1");
    send_text(1'b1);

    set_bounds(UPPER_RESET, UPPER_RESET);
    put_number(UPPER_RESET, 1'b1, 0);
    send_text(1'b1);
    put_str("1");
    send_text(1'b1);

    set_bounds(LOWER_RESET, LOWER_RESET);
    put_number(LOWER_RESET, 1'b0, 0);
    send_text(1'b1);
    put_str("-1");
    send_text(1'b1);

    // Receiver holds off while short strings keep coming: the result
    // register fills and the block has to stall its input.
    set_bounds(LOWER_RESET, UPPER_RESET);
    tx_idle_pct = 0;
    rx_hold = 1'b1;
    repeat (20) begin
      text.push_back(8'(CH_ZERO + $urandom_range(9)));
      send_text(1'b1);
    end

    // Random part: mostly numbers, often near the current bounds,
    // the rest broken strings and raw noise.
    random_end = sent_items + RANDOM_ITEMS;
    strings = 0;
    while (sent_items < random_end) begin
      if (strings % 6 == 0) begin
        case ($urandom_range(7))
          0: begin
            lo = LOWER_RESET;
            hi = UPPER_RESET;
          end
          1: begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (lo > hi) begin
              tmp = lo;
              lo = hi;
              hi = tmp;
            end
          end
          2: begin
            lo = int'($urandom_range(2000)) - 1000;
            hi = lo + $urandom_range(1000);
          end
          3: begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (lo < hi) begin
              tmp = lo;
              lo = hi;
              hi = tmp;
            end
          end
          4: begin
            lo = {$urandom, $urandom};
            hi = lo;
          end
          5: begin
            lo = LOWER_RESET;
            hi = {$urandom, $urandom};
          end
          6: begin
            lo = {$urandom, $urandom};
            hi = UPPER_RESET;
          end
          default: begin
            // Both bounds on one side of zero.
            lo = $urandom_range(1000);
            hi = lo + $urandom_range(1000000);
            if ($urandom_range(1)) begin
              tmp = lo;
              lo = -hi;
              hi = -tmp;
            end
          end
        endcase
        set_bounds(lo, hi);
        case ($urandom_range(2))
          0: tx_idle_pct = 0;
          1: tx_idle_pct = 10;
          default: tx_idle_pct = 40;
        endcase
        case ($urandom_range(2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 10;
          default: rx_idle_pct = 40;
        endcase
      end
      if (sent_items >= random_end - FLAT_OUT_ITEMS) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      kind = $urandom_range(99);
      if (kind < 70) begin
        repeat ($urandom_range(2)) begin
          ws = $urandom_range(5);
          text.push_back(ws == 5 ? CH_SPACE : 8'(CH_TAB + ws));
        end
        case ($urandom_range(3))
          0: target = sb.lower_bound + (int'($urandom_range(6)) - 3);
          1: target = sb.upper_bound + (int'($urandom_range(6)) - 3);
          2: target = int'($urandom_range(2000)) - 1000;
          default: target = {$urandom, $urandom};
        endcase
        put_number(target, $urandom_range(3) == 0,
                   $urandom_range(9) == 0 ? $urandom_range(20, 1) : 0);
        // An extra digit pushes a value near a bound past it.
        if ($urandom_range(9) == 0) text.push_back(8'(CH_ZERO + $urandom_range(9)));
        if (kind >= 55) begin
          do junk = 8'($urandom_range(255, 1));
          while (junk >= CH_ZERO && junk <= CH_NINE);
          text.push_back(junk);
        end
      end else if (kind < 85) begin
        case ($urandom_range(3))
          0: ;
          1: text = '{CH_SPACE, CH_TAB};
          2: text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
          default: text = '{CH_MINUS, CH_PLUS, 8'(CH_ZERO + $urandom_range(9))};
        endcase
      end else begin
        repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255, 1)));
      end
      // A few strings run on into the next one without a zero byte.
      send_text(kind < 95);
      strings++;
    end

    chars.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
